// ===== hdl/slb_pkg.sv =====
`timescale 1ns / 1ps

package slb_pkg;

   localparam int MAX_STRIPE_COUNT_DEF = 8;
   localparam int MAX_HOST_COUNT_DEF   = 16;

   localparam int MAPPED_HOSTS   = 16;
   localparam int STRIPE_FIELD_W = 3;
   localparam int LAST_HOST_NONE = 15;

   localparam int LOAD_W        = 16;
   localparam int TERM_W        = 8;
   localparam int ALIVE_W       = 16;
   localparam int OUT_HOST_W    = 4;
   localparam int STRIPES_CFG_W = 4;
   localparam int HOSTS_CFG_W   = 5;
   localparam int MAP_W         = 48;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRIPES_IN_USE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOSTS_IN_USE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOST_STRIPE_MAP = 2'd2;

   localparam logic OP_PICK    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== hdl/stripe_load_balancer.sv =====
`timescale 1ns / 1ps
// Release: busy stays low, result strobe on the next cycle.
// Pick: busy through a prep state, a scan of the S stripes in use by one compare unit
//   and K = 1..H host pointer steps; the result strobe rises in the same cycle busy falls.
// A new item is accepted only while busy is low; the receiver cannot stall.
// Synchronous active-high reset clears loads, query counts, host pointers (to 15),
// the rotate pointer and the configuration registers to their defaults.
module stripe_load_balancer
   import slb_pkg::*;
#(
   parameter int MAX_STRIPE_COUNT = MAX_STRIPE_COUNT_DEF,
   parameter int MAX_HOST_COUNT   = MAX_HOST_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [TERM_W-1:0]         req_term_count,
   input  logic [ALIVE_W-1:0]        req_alive_mask,
   input  logic [STRIPE_FIELD_W-1:0] req_release_stripe,
   output logic                      rsp_valid,
   output logic [OUT_HOST_W-1:0]     rsp_chosen_host,
   output logic [STRIPE_FIELD_W-1:0] rsp_chosen_stripe,
   output logic                      rsp_error_flag,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int SW     = (MAX_STRIPE_COUNT > 1) ? $clog2(MAX_STRIPE_COUNT) : 1;
   localparam int NSW    = $clog2(MAX_STRIPE_COUNT + 1);
   localparam int HW     = ($clog2(MAX_HOST_COUNT) > 4) ? $clog2(MAX_HOST_COUNT) : 4;
   localparam int NHW    = $clog2(MAX_HOST_COUNT + 1);
   localparam int MAPPED = (MAX_HOST_COUNT < MAPPED_HOSTS) ? MAX_HOST_COUNT : MAPPED_HOSTS;
   localparam int SXW    = (SW > STRIPE_FIELD_W) ? SW : STRIPE_FIELD_W;

   typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_SCAN, ST_HOST} state_type;

   state_type state_ff;

   logic [STRIPES_CFG_W-1:0] stripes_ff;
   logic [HOSTS_CFG_W-1:0]   hosts_ff;
   logic [MAP_W-1:0]         map_ff;

   logic [LOAD_W-1:0] term_load_ff [MAX_STRIPE_COUNT];
   logic [LOAD_W-1:0] query_cnt_ff [MAX_STRIPE_COUNT];
   logic [HW-1:0]     last_host_ff [MAX_STRIPE_COUNT];
   logic [SW-1:0]     rotate_ff;

   logic [TERM_W-1:0]           terms_ff;
   logic [ALIVE_W-1:0]          alive_ff;
   logic [MAX_STRIPE_COUNT-1:0] live_ff;
   logic                        all_dead_ff;
   logic [SW-1:0]               cur_ff;
   logic [NSW-1:0]              step_ff;
   logic [SW-1:0]               best_ff;
   logic [LOAD_W-1:0]           min_ff;
   logic                        found_ff;
   logic [HW-1:0]               host_ff;
   logic [NHW-1:0]              hstep_ff;

   logic                      rsp_valid_ff;
   logic [OUT_HOST_W-1:0]     rsp_host_ff;
   logic [STRIPE_FIELD_W-1:0] rsp_stripe_ff;
   logic                      rsp_error_ff;

   logic [NSW-1:0]              ns;
   logic [NHW-1:0]              nh;
   logic [MAX_STRIPE_COUNT-1:0] live_in;
   logic                        all_dead_in;
   logic [SW:0]                 cur_p1;
   logic [SW-1:0]               nxt_stripe;
   logic [SW:0]                 rot_p1;
   logic [SW-1:0]               rot_in;
   logic [SW-1:0]               rel_idx;
   logic                        rel_ok;
   logic [SW-1:0]               rd_idx;
   logic [LOAD_W-1:0]           load_rd;
   logic [LOAD_W-1:0]           qcnt_rd;
   logic                        take;
   logic [SW-1:0]               best_in;
   logic                        scan_last;
   logic [HW:0]                 host_p1;
   logic [HW-1:0]               host_nxt;
   logic                        host_live;
   logic [STRIPE_FIELD_W-1:0]   host_st;
   logic                        usable;
   logic                        host_last;
   logic [LOAD_W:0]             load_sum;
   logic [LOAD_W-1:0]           load_add;
   logic [LOAD_W-1:0]           load_sub;
   logic                        accept;
   logic                        rsp_valid_in;

   always_comb begin
      if (stripes_ff == '0) begin
         ns = NSW'(1);
      end else if (32'(stripes_ff) > MAX_STRIPE_COUNT) begin
         ns = NSW'(MAX_STRIPE_COUNT);
      end else begin
         ns = NSW'(stripes_ff);
      end
      if (hosts_ff == '0) begin
         nh = NHW'(1);
      end else if (32'(hosts_ff) > MAX_HOST_COUNT) begin
         nh = NHW'(MAX_HOST_COUNT);
      end else begin
         nh = NHW'(hosts_ff);
      end

      all_dead_in = 1'b1;
      for (int i = 0; i < MAPPED; i++) begin
         if ((32'(nh) > i) && alive_ff[i]) begin
            all_dead_in = 1'b0;
         end
      end
      for (int s = 0; s < MAX_STRIPE_COUNT; s++) begin
         live_in[s] = 1'b0;
         for (int i = 0; i < MAPPED; i++) begin
            if ((32'(nh) > i) && alive_ff[i] &&
                (32'(map_ff[STRIPE_FIELD_W*i +: STRIPE_FIELD_W]) == s)) begin
               live_in[s] = 1'b1;
            end
         end
      end

      cur_p1     = {1'b0, cur_ff} + 1'b1;
      nxt_stripe = (32'(cur_p1) >= 32'(ns)) ? '0 : SW'(cur_p1);
      rot_p1     = {1'b0, rotate_ff} + 1'b1;
      rot_in     = (32'(rot_p1) >= 32'(ns)) ? '0 : SW'(rot_p1);

      rel_idx = SW'(req_release_stripe);
      rel_ok  = 32'(req_release_stripe) < MAX_STRIPE_COUNT;

      unique case (state_ff)
         ST_SCAN: rd_idx = nxt_stripe;
         ST_HOST: rd_idx = best_ff;
         default: rd_idx = rel_idx;
      endcase
      load_rd = term_load_ff[rd_idx];
      qcnt_rd = query_cnt_ff[rd_idx];

      take      = (live_ff[nxt_stripe] || all_dead_ff) && (!found_ff || load_rd < min_ff);
      best_in   = take ? nxt_stripe : best_ff;
      scan_last = NSW'(step_ff + 1'b1) == ns;

      host_p1   = {1'b0, host_ff} + 1'b1;
      host_nxt  = (32'(host_p1) >= 32'(nh)) ? '0 : HW'(host_p1);
      host_live = (32'(host_nxt) < MAPPED_HOSTS) && alive_ff[host_nxt[3:0]];
      host_st   = (32'(host_nxt) < MAPPED_HOSTS) ?
                  map_ff[32'(host_nxt[3:0]) * STRIPE_FIELD_W +: STRIPE_FIELD_W] : '0;
      usable    = (host_live || all_dead_ff) && (SXW'(host_st) == SXW'(best_ff));
      host_last = NHW'(hstep_ff + 1'b1) == nh;

      load_sum = {1'b0, load_rd} + {{(LOAD_W+1-TERM_W){1'b0}}, terms_ff};
      load_add = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
      load_sub = (load_rd > LOAD_W'(req_term_count)) ?
                 load_rd - LOAD_W'(req_term_count) : '0;

      accept = start && (state_ff == ST_IDLE);

      rsp_valid_in = (accept && (req_operation == OP_RELEASE)) ||
                     ((state_ff == ST_HOST) && (usable || host_last));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stripes_ff   <= STRIPES_CFG_W'(1);
         hosts_ff     <= HOSTS_CFG_W'(1);
         map_ff       <= '0;
         rotate_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_STRIPE_COUNT; s++) begin
            term_load_ff[s] <= '0;
            query_cnt_ff[s] <= '0;
            last_host_ff[s] <= HW'(LAST_HOST_NONE);
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_STRIPES_IN_USE:  stripes_ff <= csr_data[STRIPES_CFG_W-1:0];
               CSR_HOSTS_IN_USE:    hosts_ff   <= csr_data[HOSTS_CFG_W-1:0];
               CSR_HOST_STRIPE_MAP: map_ff     <= csr_data[MAP_W-1:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  terms_ff <= req_term_count;
                  alive_ff <= req_alive_mask;
                  if (req_operation == OP_RELEASE) begin
                     if (rel_ok) begin
                        term_load_ff[rel_idx] <= load_sub;
                        if (qcnt_rd != '0) begin
                           query_cnt_ff[rel_idx] <= qcnt_rd - 1'b1;
                        end
                     end
                     rsp_host_ff   <= '0;
                     rsp_stripe_ff <= '0;
                     rsp_error_ff  <= 1'b0;
                  end else begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               live_ff     <= live_in;
               all_dead_ff <= all_dead_in;
               cur_ff      <= rotate_ff;
               step_ff     <= '0;
               found_ff    <= 1'b0;
               best_ff     <= '0;
               min_ff      <= '0;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               if (take) begin
                  min_ff   <= load_rd;
                  found_ff <= 1'b1;
               end
               best_ff <= best_in;
               cur_ff  <= nxt_stripe;
               step_ff <= step_ff + 1'b1;
               if (scan_last) begin
                  rotate_ff <= rot_in;
                  host_ff   <= last_host_ff[best_in];
                  hstep_ff  <= '0;
                  state_ff  <= ST_HOST;
               end
            end
            ST_HOST: begin
               host_ff  <= host_nxt;
               hstep_ff <= hstep_ff + 1'b1;
               if (usable) begin
                  term_load_ff[best_ff] <= load_add;
                  if (qcnt_rd != '1) begin
                     query_cnt_ff[best_ff] <= qcnt_rd + 1'b1;
                  end
                  last_host_ff[best_ff] <= host_nxt;
                  rsp_host_ff   <= host_nxt[OUT_HOST_W-1:0];
                  rsp_stripe_ff <= STRIPE_FIELD_W'(best_ff);
                  rsp_error_ff  <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else if (host_last) begin
                  rsp_host_ff   <= '0;
                  rsp_stripe_ff <= STRIPE_FIELD_W'(best_ff);
                  rsp_error_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_host   = rsp_host_ff;
   assign rsp_chosen_stripe = rsp_stripe_ff;
   assign rsp_error_flag    = rsp_error_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_HOST ||
                          (start && !busy && req_operation == OP_RELEASE)))
      else $error("result strobe without a finished item");

   a_pick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_PICK) |=> busy)
      else $error("pick item accepted without going busy");

   a_error_host: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_flag) |-> (rsp_chosen_host == '0))
      else $error("error result carries a host");

endmodule
